// ===== design/pfc_pkg.sv =====
// Pixel format converter package: register indexes, conversion codes and
// the configuration bundle shared by the register file and the datapath.
// No dependencies.
package pfc_pkg;

   localparam int unsigned PIXEL_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CHAN_W    = 8;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONVERSION        = 3'd0,
      CSR_SWAP_RED_BLUE     = 3'd1,
      CSR_KEEP_ALPHA        = 3'd2,
      CSR_REPLACE_WORD      = 3'd3,
      CSR_NEAR_ZERO_ALPHA   = 3'd4,
      CSR_REPLACE_THRESHOLD = 3'd5
   } csr_index_type;

   // Conversion paths (source -> destination)
   typedef enum logic [2:0] {
      CONV_8888_1555 = 3'd0,
      CONV_8888_4444 = 3'd1,
      CONV_8888_565  = 3'd2,
      CONV_8888_8888 = 3'd3,
      CONV_565_1555  = 3'd4,
      CONV_1555_1555 = 3'd5,
      CONV_4444_1555 = 3'd6
   } conv_type;

   // Alpha at or above this sets the one-bit alpha of ARGB1555
   localparam logic [CHAN_W-1:0] ALPHA1_MIN = 8'h40;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [2:0]        conversion;
      logic              swap_red_blue;
      logic              keep_alpha;
      logic [23:0]       replace_rgb;
      logic [CHAN_W-1:0] near_zero_alpha;
      logic              replace_ok;   // replace_word >= replace_threshold
   } cfg_type;

endpackage

// ===== design/pfc_csr.sv =====
// Pixel format converter register file: six configuration registers and the
// derived replacement enable. Depends on pfc_pkg.
module pfc_csr
   import pfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIXEL_W-1:0]   csr_data,
   output cfg_type              cfg
);

   logic [2:0]         conversion_ff, conversion_in;
   logic               swap_ff, swap_in;
   logic               keep_alpha_ff, keep_alpha_in;
   logic [PIXEL_W-1:0] replace_word_ff, replace_word_in;
   logic [CHAN_W-1:0]  near_zero_ff, near_zero_in;
   logic [PIXEL_W-1:0] threshold_ff, threshold_in;

   assign csr_ready = 1'b1;

   always_comb begin
      conversion_in   = conversion_ff;
      swap_in         = swap_ff;
      keep_alpha_in   = keep_alpha_ff;
      replace_word_in = replace_word_ff;
      near_zero_in    = near_zero_ff;
      threshold_in    = threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONVERSION:        conversion_in   = csr_data[2:0];
            CSR_SWAP_RED_BLUE:     swap_in         = csr_data[0];
            CSR_KEEP_ALPHA:        keep_alpha_in   = csr_data[0];
            CSR_REPLACE_WORD:      replace_word_in = csr_data;
            CSR_NEAR_ZERO_ALPHA:   near_zero_in    = csr_data[CHAN_W-1:0];
            CSR_REPLACE_THRESHOLD: threshold_in    = csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conversion_ff   <= CONV_8888_1555;
         swap_ff         <= 1'b0;
         keep_alpha_ff   <= 1'b1;
         replace_word_ff <= '0;
         near_zero_ff    <= '0;
         threshold_ff    <= '1;
      end else begin
         conversion_ff   <= conversion_in;
         swap_ff         <= swap_in;
         keep_alpha_ff   <= keep_alpha_in;
         replace_word_ff <= replace_word_in;
         near_zero_ff    <= near_zero_in;
         threshold_ff    <= threshold_in;
      end
   end

   always_comb begin
      cfg.conversion      = conversion_ff;
      cfg.swap_red_blue   = swap_ff;
      cfg.keep_alpha      = keep_alpha_ff;
      cfg.replace_rgb     = replace_word_ff[23:0];
      cfg.near_zero_alpha = near_zero_ff;
      cfg.replace_ok      = (replace_word_ff >= threshold_ff);
   end

endmodule

// ===== design/pfc_convert.sv =====
// Pixel format converter datapath: unpack, swap, premultiply, replace,
// force opaque and pack, all combinational. Depends on pfc_pkg.
module pfc_convert
   import pfc_pkg::*;
(
   input  cfg_type            cfg,
   input  logic [PIXEL_W-1:0] pixel,
   output logic [PIXEL_W-1:0] result
);

   // floor(x / 255) for x up to 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return s[15:8];
   endfunction

   logic [15:0]       h;
   logic [CHAN_W-1:0] a_src, r_src, g_src, b_src;
   logic [CHAN_W-1:0] r_sw, b_sw;
   logic [15:0]       prod_r, prod_g, prod_b;
   logic [CHAN_W-1:0] r_pm, g_pm, b_pm;
   logic [CHAN_W-1:0] a_fin, r_fin, g_fin, b_fin;
   logic              path_ok, apply_replace, apply_force, premult;

   assign h = pixel[15:0];

   // Unpack; narrow channels widen by replicating their top bits
   always_comb begin
      a_src         = pixel[31:24];
      r_src         = pixel[23:16];
      g_src         = pixel[15:8];
      b_src         = pixel[7:0];
      path_ok       = 1'b1;
      apply_replace = 1'b1;
      apply_force   = 1'b1;
      premult       = 1'b0;
      case (cfg.conversion)
         CONV_8888_1555, CONV_8888_4444, CONV_8888_8888: ;
         CONV_8888_565: begin
            premult     = 1'b1;
            apply_force = 1'b0;
         end
         CONV_565_1555: begin
            b_src         = {h[4:0], h[4:2]};
            g_src         = {h[10:5], h[10:9]};
            r_src         = {h[15:11], h[15:13]};
            a_src         = ALPHA_OPAQUE;
            apply_replace = 1'b0;
            apply_force   = 1'b0;
         end
         CONV_1555_1555: begin
            b_src = {h[4:0], h[4:2]};
            g_src = {h[9:5], h[9:7]};
            r_src = {h[14:10], h[14:12]};
            a_src = h[15] ? ALPHA_OPAQUE : '0;
         end
         CONV_4444_1555: begin
            b_src = {h[3:0], h[3:0]};
            g_src = {h[7:4], h[7:4]};
            r_src = {h[11:8], h[11:8]};
            a_src = {h[15:12], h[15:12]};
         end
         default: path_ok = 1'b0;
      endcase
   end

   assign r_sw = cfg.swap_red_blue ? b_src : r_src;
   assign b_sw = cfg.swap_red_blue ? r_src : b_src;

   // Premultiply by alpha/255, rounding down (565 output only)
   assign prod_r = r_sw * a_src;
   assign prod_g = g_src * a_src;
   assign prod_b = b_sw * a_src;
   assign r_pm   = premult ? div255(prod_r) : r_sw;
   assign g_pm   = premult ? div255(prod_g) : g_src;
   assign b_pm   = premult ? div255(prod_b) : b_sw;

   always_comb begin
      r_fin = r_pm;
      g_fin = g_pm;
      b_fin = b_pm;
      a_fin = a_src;
      // replacement tests the source alpha, before any forcing
      if (apply_replace && cfg.replace_ok && (a_src <= cfg.near_zero_alpha)) begin
         r_fin = cfg.replace_rgb[23:16];
         g_fin = cfg.replace_rgb[15:8];
         b_fin = cfg.replace_rgb[7:0];
      end
      if (apply_force && !cfg.keep_alpha) begin
         a_fin = ALPHA_OPAQUE;
      end
   end

   // Pack
   always_comb begin
      result = '0;
      if (path_ok) begin
         case (cfg.conversion)
            CONV_8888_4444:
               result = {16'd0, a_fin[7:4], r_fin[7:4], g_fin[7:4], b_fin[7:4]};
            CONV_8888_565:
               result = {16'd0, r_fin[7:3], g_fin[7:2], b_fin[7:3]};
            CONV_8888_8888:
               result = {a_fin, r_fin, g_fin, b_fin};
            default:
               result = {16'd0, (a_fin >= ALPHA1_MIN), r_fin[7:3], g_fin[7:3], b_fin[7:3]};
         endcase
      end
   end

endmodule

// ===== design/pixel_format_converter.sv =====
// Pixel format converter top level: input register, conversion datapath and
// result register with valid/stall flow control. Depends on pfc_pkg,
// pfc_csr and pfc_convert.
//
// Converts one packed pixel per item between ARGB8888, ARGB4444, ARGB1555
// and RGB565 as selected by the conversion register. Throughput is one item
// per clock while rsp_stall is low. An item accepted on req_ sits in the
// input register and goes through the conversion logic into the result
// register once that register is free; rsp_valid then rises. The per-item
// work is a single pass of unpack, red/blue swap, 8x8 premultiply with
// divide-by-255, colour replacement and packing; that path sets the clock
// rate. Results that are stalled are held in the result register while the
// input register keeps taking one more item, so req_stall only rises when
// both registers hold items and rsp_stall is high. Configuration writes take
// effect in the following cycle (csr_ready is always high) and must only be
// issued while no item is in flight. 16-bit results sit in bits 15..0 of
// rsp_pixel_out with the upper half zero; conversion code 7 yields zero.
module pixel_format_converter
   import pfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // pixel input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIXEL_W-1:0]   req_pixel_in,
   // converted pixel output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIXEL_W-1:0]   rsp_pixel_out,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIXEL_W-1:0]   csr_data
);

   cfg_type            cfg;
   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] in_pixel_ff, in_pixel_in;
   logic               out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic [PIXEL_W-1:0] conv_pixel;
   logic               out_free;

   pfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pfc_convert u_convert (
      .cfg    (cfg),
      .pixel  (in_pixel_ff),
      .result (conv_pixel)
   );

   // Result register can take a new item when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // Input register blocks only when it holds an item that cannot move on
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      in_pixel_in  = (req_valid && !req_stall) ? req_pixel_in : in_pixel_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      out_pixel_in = (out_free && in_valid_ff) ? conv_pixel : out_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_pixel_ff  <= in_pixel_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;

endmodule

// ===== design/pfc_checker.sv =====
// Port-level checks for the pixel format converter, bound to the top level.
// Depends on pfc_pkg.
module pfc_checker
   import pfc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PIXEL_W-1:0] rsp_pixel_out
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_out))
      else $error("rsp_pixel_out changed while stalled");

   // input backpressure only when the output side is holding an item
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled result");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("item pending after reset");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (.*);

// ===== bench/pixel_format_converter_tb.sv =====
// Self-checking bench for pixel_format_converter: directed and random pixels over
// all conversion paths, with a built-in predictor and random stalls on both sides.
// Depends on pfc_pkg and the pixel_format_converter RTL.
module pixel_format_converter_tb
   import pfc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Conversion code with no path behind it; the block must return zero
   localparam logic [2:0] CONV_UNDEFINED = 3'd7;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned PHASE_ITEMS   = 95;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [PIXEL_W-1:0]   req_pixel_in  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [PIXEL_W-1:0]   rsp_pixel_out;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [PIXEL_W-1:0]   csr_data      = '0;

   pixel_format_converter u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 2 ns period
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Shadow copy of the block's configuration, updated on each accepted CSR write
   logic [2:0]  conv_sel       = CONV_8888_1555;
   logic        swap_rb        = 1'b0;
   logic        keep_alpha_en  = 1'b1;
   logic [31:0] repl_word      = 32'h0;
   logic [7:0]  near_zero      = 8'h00;
   logic [31:0] repl_threshold = 32'hFFFF_FFFF;

   logic [PIXEL_W-1:0] source_pixels[$];    // items waiting for the driver
   logic [PIXEL_W-1:0] predicted_pixels[$]; // expected outputs, oldest first

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned pixels_sent    = 0;
   int unsigned pixels_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned orphan_count   = 0;
   int unsigned settings_count = 0;
   int unsigned cycle_count    = 0;

   // Predicted output pixel for one source pixel under the current settings.
   function automatic logic [31:0] convert_pixel(logic [31:0] pix);
      logic [15:0] h;
      logic [7:0]  a, r, g, b, t;
      logic [15:0] prod;
      logic        do_replace;
      logic        do_force;
      h          = pix[15:0];
      do_replace = 1'b1;
      do_force   = 1'b1;
      // unpack to 8-bit channels, widening by bit replication
      case (conv_sel)
         CONV_8888_1555, CONV_8888_4444, CONV_8888_565, CONV_8888_8888: begin
            {a, r, g, b} = pix;
         end
         CONV_565_1555: begin
            r          = {h[15:11], h[15:13]};
            g          = {h[10:5], h[10:9]};
            b          = {h[4:0], h[4:2]};
            a          = ALPHA_OPAQUE;
            do_replace = 1'b0;
            do_force   = 1'b0;
         end
         CONV_1555_1555: begin
            r = {h[14:10], h[14:12]};
            g = {h[9:5], h[9:7]};
            b = {h[4:0], h[4:2]};
            a = h[15] ? ALPHA_OPAQUE : 8'h00;
         end
         CONV_4444_1555: begin
            a = {h[15:12], h[15:12]};
            r = {h[11:8], h[11:8]};
            g = {h[7:4], h[7:4]};
            b = {h[3:0], h[3:0]};
         end
         default: begin
            return 32'h0;
         end
      endcase
      if (swap_rb) begin
         t = b;
         b = r;
         r = t;
      end
      // premultiplied 565: channel * alpha / 255, rounded down, never forced opaque
      if (conv_sel == CONV_8888_565) begin
         prod     = r * a;
         r        = 8'(prod / 16'd255);
         prod     = g * a;
         g        = 8'(prod / 16'd255);
         prod     = b * a;
         b        = 8'(prod / 16'd255);
         do_force = 1'b0;
      end
      // replacement colour for near-transparent pixels, alpha untouched
      if (do_replace && a <= near_zero && repl_word >= repl_threshold) begin
         r = repl_word[23:16];
         g = repl_word[15:8];
         b = repl_word[7:0];
      end
      if (do_force && !keep_alpha_en) begin
         a = ALPHA_OPAQUE;
      end
      case (conv_sel)
         CONV_8888_4444: return {16'h0, a[7:4], r[7:4], g[7:4], b[7:4]};
         CONV_8888_565:  return {16'h0, r[7:3], g[7:2], b[7:3]};
         CONV_8888_8888: return {a, r, g, b};
         default:        return {16'h0, a >= ALPHA1_MIN, r[7:3], g[7:3], b[7:3]};
      endcase
   endfunction

   // Random source pixel, biased toward near-transparent alphas for the 8888, 1555 and 4444 sources
   function automatic logic [31:0] random_pixel();
      logic [31:0] pix;
      pix = $urandom;
      case ($urandom_range(0, 5))
         0: pix[31:24] = 8'($urandom_range(0, near_zero));
         1: begin
            pix[15]    = 1'b0;                                     // 1555 transparent
            pix[15:12] = 4'($urandom_range(0, near_zero[7:4])) & 4'h7;
         end
         2: pix[15:12] = 4'($urandom_range(0, near_zero[7:4]));   // 4444 low alpha
         3: pix = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: ;
      endcase
      return pix;
   endfunction

   // Source side: one item in flight on req_, held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_pixels.push_back(convert_pixel(req_pixel_in));
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (source_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid    <= 1'b1;
               req_pixel_in <= source_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each accepted output against the oldest prediction
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_pixels.size() == 0) begin
               orphan_count++;
               if (mismatch_count + orphan_count <= MAX_REPORTS) begin
                  $display("ERROR: output %h with no item pending", rsp_pixel_out);
               end
            end else begin
               want = predicted_pixels.pop_front();
               pixels_checked++;
               if (rsp_pixel_out !== want) begin
                  mismatch_count++;
                  if (mismatch_count + orphan_count <= MAX_REPORTS) begin
                     $display("ERROR: pixel_out mismatch, expected %h got %h (conversion %0d)",
                              want, rsp_pixel_out, conv_sel);
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // One register write; leaves csr_valid high so back-to-back writes need no gap.
   // Called right after a rising edge, returns at the edge that takes the write.
   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CONVERSION:        conv_sel       = data[2:0];
         CSR_SWAP_RED_BLUE:     swap_rb        = data[0];
         CSR_KEEP_ALPHA:        keep_alpha_en  = data[0];
         CSR_REPLACE_WORD:      repl_word      = data;
         CSR_NEAR_ZERO_ALPHA:   near_zero      = data[7:0];
         CSR_REPLACE_THRESHOLD: repl_threshold = data;
         default: ;
      endcase
   endtask

   // Full register set; only called while nothing is in flight
   task automatic load_config(logic [2:0] conv, logic swap, logic keep,
                              logic [31:0] word, logic [7:0] nza, logic [31:0] thr);
      write_csr(CSR_CONVERSION, {29'h0, conv});
      write_csr(CSR_SWAP_RED_BLUE, {31'h0, swap});
      write_csr(CSR_KEEP_ALPHA, {31'h0, keep});
      write_csr(CSR_REPLACE_WORD, word);
      write_csr(CSR_NEAR_ZERO_ALPHA, {24'h0, nza});
      write_csr(CSR_REPLACE_THRESHOLD, thr);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Wait until every queued item went in and every output came back out of
   // the two-stage pipeline.
   task automatic drain();
      do @(posedge clock);
      while (source_pixels.size() != 0 || req_valid || predicted_pixels.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // 32-bit register value: mostly random, with both extremes
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] word, thr;
      logic [7:0]  nza;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      send_idle_pct  = 15;
      recv_stall_pct = 50;

      // 1555 alpha bit around 0x40; alpha 0x3F is near transparent and gets the
      // replacement colour (threshold 0 keeps replacement enabled)
      load_config(CONV_8888_1555, 1'b0, 1'b1, 32'h0012_3456, 8'h3F, 32'h0);
      source_pixels = {32'h3FAA_BBCC, 32'h40FF_FFFF, 32'h0000_0000};
      drain();

      // 4444 with swap and forced opaque
      load_config(CONV_8888_4444, 1'b1, 1'b0, 32'h0, 8'h00, 32'hFFFF_FFFF);
      source_pixels = {32'hFFFF_FFFF, 32'h1234_5678};
      drain();

      // premultiplied 565; the replacement colour skips the premultiply
      load_config(CONV_8888_565, 1'b0, 1'b0, 32'hFFFF_FFFF, 8'h20, 32'hFFFF_FFFF);
      source_pixels = {32'h80FF_8040, 32'h10FF_FFFF, 32'hFFFF_FFFF};
      drain();

      // pass-through 8888, alpha forced opaque
      load_config(CONV_8888_8888, 1'b0, 1'b0, 32'h0, 8'hFF, 32'h1);
      source_pixels = {32'h00AB_CDEF, 32'hFFFF_FFFF};
      drain();

      // 565 source: no replacement, no forcing, upper half ignored
      load_config(CONV_565_1555, 1'b1, 1'b0, 32'h00FF_00FF, 8'hFF, 32'h0);
      source_pixels = {32'hFFFF_0000, 32'h0000_FFFF, 32'hABCD_1234};
      drain();

      // 1555 source: alpha from bit 15 only
      load_config(CONV_1555_1555, 1'b0, 1'b1, 32'h00C0_FFEE, 8'h00, 32'h00C0_FFEE);
      source_pixels = {32'h0000_8000, 32'hFFFF_7FFF, 32'h0000_FFFF};
      drain();

      // 4444 source
      load_config(CONV_4444_1555, 1'b1, 1'b1, 32'h0, 8'h3F, 32'h0);
      source_pixels = {32'h0000_F0F0, 32'hFFFF_0FFF, 32'h0000_3ABC};
      drain();

      // undefined code returns zero
      load_config(CONV_UNDEFINED, 1'b0, 1'b1, 32'h0, 8'h00, 32'hFFFF_FFFF);
      source_pixels = {32'hFFFF_FFFF, 32'h1234_5678};
      drain();

      // ---- random part: three idle regimes, three settings each ----
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph / 3)
            0: begin
               send_idle_pct  = 15;
               recv_stall_pct = 50;
            end
            1: begin
               send_idle_pct  = 50;
               recv_stall_pct = 15;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         if (ph == 0) begin
            load_config(CONV_8888_1555, 1'b0, 1'b0, 32'h0, 8'h00, 32'h0);
         end else if (ph == 1) begin
            load_config(CONV_8888_4444, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
         end else begin
            word = pick_word();
            thr  = $urandom_range(0, 1) ? pick_word() : word;
            nza  = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(0, 255));
            load_config(3'(ph % 7), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        word, nza, thr);
         end
         repeat (PHASE_ITEMS) source_pixels.push_back(random_pixel());
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d pixels through %0d register settings covering all conversion codes,",
               pixels_sent, settings_count);
      $display("checked %0d outputs under sender-side and receiver-side stalls.",
               pixels_checked);
      if (mismatch_count == 0 && orphan_count == 0 && predicted_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
